// ===== hw/rtl/sfq_pkg.sv =====
// Shared constants, types and helpers of the searchable FIFO queue.
package sfq_pkg;

  // Queue geometry and field widths
  localparam int unsigned DEPTH       = 16;
  localparam int unsigned KEY_BITS    = 64;
  localparam int unsigned HEIGHT_BITS = 10;
  localparam int unsigned PTR_BITS    = $clog2(DEPTH);
  localparam int unsigned CNT_BITS    = $clog2(DEPTH + 1);
  localparam int unsigned CMD_BITS    = 3;
  localparam int unsigned STAT_BITS   = 2;

  // Stream packing: request data and result data, padded to whole bytes
  localparam int unsigned IN_RAW_BITS   = 2 * KEY_BITS + 2 * HEIGHT_BITS;
  localparam int unsigned IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_BITS  = STAT_BITS + KEY_BITS + HEIGHT_BITS + CNT_BITS + 1;
  localparam int unsigned OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  // Bit offsets inside the result data word
  localparam int unsigned OUT_NAME_LSB   = STAT_BITS;
  localparam int unsigned OUT_HEIGHT_LSB = OUT_NAME_LSB + KEY_BITS;
  localparam int unsigned OUT_OCC_LSB    = OUT_HEIGHT_LSB + HEIGHT_BITS;
  localparam int unsigned OUT_EMPTY_BIT  = OUT_OCC_LSB + CNT_BITS;

  // Result status codes
  localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_EMPTY = 2'd2;

  // Command codes
  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_STATUS = 3'd2,
    CMD_LIST   = 3'd3,
    CMD_FIND   = 3'd4
  } cmd_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_CHECK,
    ST_FLUSH
  } state_e;

  // One result record as held in the output register
  typedef struct packed {
    logic                   last;
    logic                   is_empty;
    logic [CNT_BITS-1:0]    occupancy;
    logic [HEIGHT_BITS-1:0] rec_height;
    logic [KEY_BITS-1:0]    rec_name;
    logic                   hit;
    logic [STAT_BITS-1:0]   status;
  } result_t;

  // Advance a ring pointer with wrap at DEPTH
  function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== hw/rtl/searchable_fifo_queue_top.sv =====
// Searchable FIFO queue of name/height records with push, pop, threshold list and name find.
//
// The queue holds up to DEPTH records in a ring memory with one write and one registered
// read port; a height and a name comparator under a small sequencer walk the ring for
// searches. A list or find request walks the queued records (up to DEPTH) from the oldest,
// one entry per cycle through the read port, except while a match waits for the result
// register to drain; a find stops at its first match. Each request yields one result, except
// a list with matches, which yields one result per record at or above the threshold in queue
// order; tlast marks the final result of a request. The block takes no new request while one
// is in progress, but does take one while its last result still waits in the output register.
module searchable_fifo_queue_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request channel
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // entry_name[63:0], entry_height[73:64], min_height[83:74], query_name[147:84], zero pad
  input  logic [sfq_pkg::IN_DATA_BITS-1:0]  s_axis_tdata_i,
  // cmd[2:0]
  input  logic [sfq_pkg::CMD_BITS-1:0]      s_axis_tuser_i,
  // Result channel
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // status[1:0], rec_name[65:2], rec_height[75:66], occupancy[80:76], is_empty[81], zero pad
  output logic [sfq_pkg::OUT_DATA_BITS-1:0] m_axis_tdata_o,
  // hit[0]
  output logic                              m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);

  localparam int unsigned KB = sfq_pkg::KEY_BITS;
  localparam int unsigned HB = sfq_pkg::HEIGHT_BITS;
  localparam int unsigned PB = sfq_pkg::PTR_BITS;
  localparam int unsigned CB = sfq_pkg::CNT_BITS;

  // Record storage
  logic [KB-1:0] name_mem   [sfq_pkg::DEPTH];
  logic [HB-1:0] height_mem [sfq_pkg::DEPTH];

  sfq_pkg::state_e state_q, state_d;

  // Captured request
  logic [sfq_pkg::CMD_BITS-1:0] cmd_q;
  logic [KB-1:0]                entry_name_q;
  logic [HB-1:0]                entry_height_q;
  logic [HB-1:0]                min_height_q;
  logic [KB-1:0]                query_name_q;

  // Ring pointers, fill count and scan position
  logic [PB-1:0] head_q, head_d;
  logic [PB-1:0] tail_q, tail_d;
  logic [CB-1:0] count_q, count_d;
  logic [PB-1:0] scan_q, scan_d;
  logic [CB-1:0] idx_q, idx_d;

  // Memory port signals
  logic          wr_en;
  logic [PB-1:0] rd_addr;
  logic [KB-1:0] rd_name_q;
  logic [HB-1:0] rd_height_q;

  // Pending list match, held until the next match or the end of the walk
  logic          pend_valid_q, pend_valid_d;
  logic          pend_load;
  logic [KB-1:0] pend_name_q;
  logic [HB-1:0] pend_height_q;

  // Output register
  logic              out_valid_q, out_valid_d;
  sfq_pkg::result_t  out_q;
  sfq_pkg::result_t  emit_rec;
  logic              emit_en;

  logic req_acc;
  logic can_emit;
  logic is_full;
  logic is_empty;
  logic last_entry;
  logic list_match;
  logic find_match;

  assign req_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign can_emit   = !out_valid_q || m_axis_tready_i;
  assign is_full    = (count_q == CB'(sfq_pkg::DEPTH));
  assign is_empty   = (count_q == '0);
  assign last_entry = ((idx_q + 1'b1) == count_q);
  assign list_match = (rd_height_q >= min_height_q);
  assign find_match = (rd_name_q == query_name_q);

  assign s_axis_tready_o = (state_q == sfq_pkg::ST_IDLE);

  // Hold the state register and bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sfq_pkg::ST_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      scan_q       <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      scan_q       <= scan_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Capture request fields on accept
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q          <= s_axis_tuser_i;
      entry_name_q   <= s_axis_tdata_i[KB-1:0];
      entry_height_q <= s_axis_tdata_i[KB +: HB];
      min_height_q   <= s_axis_tdata_i[KB + HB +: HB];
      query_name_q   <= s_axis_tdata_i[KB + 2*HB +: KB];
    end
  end

  // Write at the tail, read registered at the selected address
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      name_mem[tail_q]   <= entry_name_q;
      height_mem[tail_q] <= entry_height_q;
    end
    rd_name_q   <= name_mem[rd_addr];
    rd_height_q <= height_mem[rd_addr];
  end

  // Hold the pending list match
  always_ff @(posedge clk_i) begin
    if (pend_load) begin
      pend_name_q   <= rd_name_q;
      pend_height_q <= rd_height_q;
    end
  end

  // Load the output register on emit
  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      out_q <= emit_rec;
    end
  end

  // Sequence requests: decode, walk the ring, emit results
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    scan_d       = scan_q;
    idx_d        = idx_q;
    rd_addr      = scan_q;
    wr_en        = 1'b0;
    pend_valid_d = pend_valid_q;
    pend_load    = 1'b0;
    emit_en      = 1'b0;
    emit_rec     = '0;
    emit_rec.status = sfq_pkg::STAT_OK;
    emit_rec.last   = 1'b1;

    case (state_q)
      sfq_pkg::ST_IDLE: begin
        if (req_acc) begin
          state_d = sfq_pkg::ST_EXEC;
        end
      end

      sfq_pkg::ST_EXEC: begin
        case (cmd_q)
          sfq_pkg::CMD_PUSH: begin
            if (can_emit) begin
              emit_en = 1'b1;
              state_d = sfq_pkg::ST_IDLE;
              if (is_full) begin
                emit_rec.status = sfq_pkg::STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                tail_d  = sfq_pkg::ptr_next(tail_q);
                count_d = count_q + 1'b1;
              end
            end
          end
          sfq_pkg::CMD_POP, sfq_pkg::CMD_LIST, sfq_pkg::CMD_FIND: begin
            if (is_empty) begin
              if (can_emit) begin
                emit_en         = 1'b1;
                emit_rec.status = sfq_pkg::STAT_EMPTY;
                state_d         = sfq_pkg::ST_IDLE;
              end
            end else begin
              // Start reading at the oldest record
              scan_d       = head_q;
              rd_addr      = head_q;
              idx_d        = '0;
              pend_valid_d = 1'b0;
              state_d      = (cmd_q == sfq_pkg::CMD_POP) ? sfq_pkg::ST_POP
                                                         : sfq_pkg::ST_CHECK;
            end
          end
          default: begin
            if (can_emit) begin
              emit_en = 1'b1;
              state_d = sfq_pkg::ST_IDLE;
            end
          end
        endcase
      end

      sfq_pkg::ST_POP: begin
        if (can_emit) begin
          emit_en             = 1'b1;
          emit_rec.hit        = 1'b1;
          emit_rec.rec_name   = rd_name_q;
          emit_rec.rec_height = rd_height_q;
          head_d              = sfq_pkg::ptr_next(head_q);
          count_d             = count_q - 1'b1;
          state_d             = sfq_pkg::ST_IDLE;
        end
      end

      sfq_pkg::ST_CHECK: begin
        if (cmd_q == sfq_pkg::CMD_FIND) begin
          if (find_match) begin
            if (can_emit) begin
              emit_en             = 1'b1;
              emit_rec.hit        = 1'b1;
              emit_rec.rec_name   = rd_name_q;
              emit_rec.rec_height = rd_height_q;
              state_d             = sfq_pkg::ST_IDLE;
            end
          end else if (last_entry) begin
            if (can_emit) begin
              emit_en = 1'b1;
              state_d = sfq_pkg::ST_IDLE;
            end
          end else begin
            scan_d  = sfq_pkg::ptr_next(scan_q);
            rd_addr = scan_d;
            idx_d   = idx_q + 1'b1;
          end
        end else if (!(list_match && pend_valid_q && !can_emit)) begin
          // Release the previous match, keep this one pending
          if (list_match) begin
            if (pend_valid_q) begin
              emit_en             = 1'b1;
              emit_rec.hit        = 1'b1;
              emit_rec.rec_name   = pend_name_q;
              emit_rec.rec_height = pend_height_q;
              emit_rec.last       = 1'b0;
            end
            pend_load    = 1'b1;
            pend_valid_d = 1'b1;
          end
          if (last_entry) begin
            state_d = sfq_pkg::ST_FLUSH;
          end else begin
            scan_d  = sfq_pkg::ptr_next(scan_q);
            rd_addr = scan_d;
            idx_d   = idx_q + 1'b1;
          end
        end
      end

      sfq_pkg::ST_FLUSH: begin
        if (can_emit) begin
          emit_en = 1'b1;
          if (pend_valid_q) begin
            emit_rec.hit        = 1'b1;
            emit_rec.rec_name   = pend_name_q;
            emit_rec.rec_height = pend_height_q;
          end
          pend_valid_d = 1'b0;
          state_d      = sfq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sfq_pkg::ST_IDLE;
      end
    endcase

    // Report occupancy after the request
    emit_rec.occupancy = count_d;
    emit_rec.is_empty  = (count_d == '0);

    // Advance the output register
    if (emit_en) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Drive the result channel
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.hit;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {{(sfq_pkg::OUT_DATA_BITS - sfq_pkg::OUT_RAW_BITS){1'b0}},
                            out_q.is_empty, out_q.occupancy, out_q.rec_height,
                            out_q.rec_name, out_q.status};

endmodule

// ===== hw/rtl/sfq_checker.sv =====
// Port-level checks of the searchable FIFO queue, bound to its top level.
module sfq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [sfq_pkg::IN_DATA_BITS-1:0]  s_axis_tdata_i,
  input logic [sfq_pkg::CMD_BITS-1:0]      s_axis_tuser_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [sfq_pkg::OUT_DATA_BITS-1:0] m_axis_tdata_o,
  input logic                              m_axis_tuser_o,
  input logic                              m_axis_tlast_o
);

  logic [sfq_pkg::STAT_BITS-1:0] res_status;
  logic [sfq_pkg::CNT_BITS-1:0]  res_occ;
  logic                          res_empty;

  assign res_status = m_axis_tdata_o[sfq_pkg::STAT_BITS-1:0];
  assign res_occ    = m_axis_tdata_o[sfq_pkg::OUT_OCC_LSB +: sfq_pkg::CNT_BITS];
  assign res_empty  = m_axis_tdata_o[sfq_pkg::OUT_EMPTY_BIT];

  // A stalled result stays offered
  property p_result_held;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o;
  endproperty
  a_result_held: assert property (p_result_held) else $error("result dropped while stalled");

  // One request at a time: no accept right after an accept
  property p_one_request;
    @(posedge clk_i) disable iff (!rst_ni)
      s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o;
  endproperty
  a_one_request: assert property (p_one_request) else $error("request taken while busy");

  // Occupancy bounded and consistent with the empty flag
  property p_occ_consistent;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o |-> (res_occ <= sfq_pkg::CNT_BITS'(sfq_pkg::DEPTH)) &&
                          (res_empty == (res_occ == '0));
  endproperty
  a_occ_consistent: assert property (p_occ_consistent) else $error("bad occupancy");

  // An error result carries no record and closes the request
  property p_error_alone;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o && (res_status != sfq_pkg::STAT_OK) |-> !m_axis_tuser_o && m_axis_tlast_o;
  endproperty
  a_error_alone: assert property (p_error_alone) else $error("error result with record");

endmodule

bind searchable_fifo_queue_top sfq_checker u_sfq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
